// ===== design/okvl_pkg.sv =====
package okvl_pkg;

  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int LEN_W        = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } okvl_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } okvl_state_t;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } okvl_in_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] found_value;
    logic [LEN_W-1:0] length;
    logic             empty_res;
    logic             full_res;
  } okvl_out_t;

  typedef struct packed {
    logic             tok;
    logic             seen;
    logic [VAL_W-1:0] fval;
  } okvl_link_t;

endpackage

// ===== design/ordered_key_value_list.sv =====
// Channel   Ports                        Handshake
// request   start, busy, in_req          taken when start is high and busy low
// result    out_strobe, out_res          one-cycle strobe, always taken
//
// An operation travels cell by cell down the chain, one cell per cycle.
// Each request passes the launch register, every cell and the result register;
// the next request may be taken in the strobe cycle.
// Reset empties the list; stored keys and data are not cleared.
// The receiver cannot stall; busy is high only while a request is in the chain.
module ordered_key_value_list #(
  parameter int CAPACITY = okvl_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  okvl_pkg::okvl_in_t  in_req,
  output logic                out_strobe,
  output okvl_pkg::okvl_out_t out_res
);
  import okvl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  okvl_state_t      state_r, state_nxt;
  okvl_in_t         cmd_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             launch_r;
  okvl_out_t        res_r, res_nxt;
  logic             accept;
  logic             done;
  logic             hit;
  logic [VAL_W-1:0] fv;

  okvl_link_t       lnk [CAPACITY+1];
  logic [KEY_W-1:0] kq  [CAPACITY];
  logic [VAL_W-1:0] vq  [CAPACITY];

  assign accept = start && !busy;

  assign lnk[0].tok  = launch_r;
  assign lnk[0].seen = 1'b0;
  assign lnk[0].fval = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] nk;
    logic [VAL_W-1:0] nv;
    if (i < CAPACITY - 1) begin : g_mid
      assign nk = kq[i+1];
      assign nv = vq[i+1];
    end else begin : g_last
      assign nk = '0;
      assign nv = '0;
    end
    okvl_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_r),
      .cnt     (cnt_r),
      .lnk_i   (lnk[i]),
      .lnk_o   (lnk[i+1]),
      .nxt_key (nk),
      .nxt_val (nv),
      .key_o   (kq[i]),
      .val_o   (vq[i])
    );
  end

  assign done = (state_r == ST_RUN) && lnk[CAPACITY].tok;
  assign hit  = lnk[CAPACITY].seen;
  assign fv   = lnk[CAPACITY].fval;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (done) state_nxt = ST_DONE;
      ST_DONE: state_nxt = start ? ST_RUN : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    out_strobe = 1'b0;
    case (state_r)
      ST_RUN:  busy = 1'b1;
      ST_DONE: out_strobe = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    if (done) begin
      res_nxt.ok          = hit;
      res_nxt.found_value = '0;
      case (cmd_r.action)
        ACT_INSERT: if (hit) cnt_nxt = cnt_r + CW'(1);
        ACT_DELETE: if (hit) cnt_nxt = cnt_r - CW'(1);
        ACT_SEARCH: res_nxt.found_value = hit ? fv : '0;
        default: begin
          cnt_nxt    = '0;
          res_nxt.ok = 1'b1;
        end
      endcase
      res_nxt.length    = LEN_W'(cnt_nxt);
      res_nxt.empty_res = (cnt_nxt == '0);
      res_nxt.full_res  = (cnt_nxt == CW'(CAPACITY));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      launch_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_req;
    end
    res_r <= res_nxt;
  end

  assign out_res = res_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> launch_r)
    else $error("accepted request not launched into chain");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    done && (cmd_r.action == ACT_INSERT) && hit |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the list");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_res.empty_res && out_res.full_res))
    else $error("list both empty and full");
`endif

endmodule

// ===== design/okvl_cell.sv =====
module okvl_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  okvl_pkg::okvl_in_t    cmd,
  input  logic [CW-1:0]         cnt,
  input  okvl_pkg::okvl_link_t  lnk_i,
  output okvl_pkg::okvl_link_t  lnk_o,
  input  logic [okvl_pkg::KEY_W-1:0] nxt_key,
  input  logic [okvl_pkg::VAL_W-1:0] nxt_val,
  output logic [okvl_pkg::KEY_W-1:0] key_o,
  output logic [okvl_pkg::VAL_W-1:0] val_o
);
  import okvl_pkg::*;

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             tok_r;
  logic             seen_r, seen_nxt;
  logic [VAL_W-1:0] fval_r, fval_nxt;
  logic             live;
  logic             match;
  logic             here;
  logic             hit;

  assign live  = (cnt > CW'(IDX));
  assign here  = (cnt == CW'(IDX));
  assign match = live && (key_r == KEY_W'(cmd.key));
  assign hit   = lnk_i.seen | match;

  always_comb begin
    key_nxt  = key_r;
    val_nxt  = val_r;
    seen_nxt = seen_r;
    fval_nxt = fval_r;
    if (lnk_i.tok) begin
      seen_nxt = hit;
      fval_nxt = '0;
      case (cmd.action)
        ACT_INSERT: begin
          seen_nxt = lnk_i.seen | here;
          if (here) begin
            key_nxt = KEY_W'(cmd.key);
            val_nxt = cmd.value;
          end
        end
        ACT_DELETE: begin
          if (hit) begin
            key_nxt = nxt_key;
            val_nxt = nxt_val;
          end
        end
        ACT_SEARCH: begin
          fval_nxt = lnk_i.seen ? lnk_i.fval : (match ? val_r : '0);
        end
        default: begin
          seen_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= lnk_i.tok;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    seen_r <= seen_nxt;
    fval_r <= fval_nxt;
  end

  assign lnk_o.tok  = tok_r;
  assign lnk_o.seen = seen_r;
  assign lnk_o.fval = fval_r;
  assign key_o      = key_r;
  assign val_o      = val_r;

endmodule

// ===== dv/tb_ordered_key_value_list.sv =====
module tb_ordered_key_value_list;
  import okvl_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int N_RANDOM   = 1600;
  localparam int POOL       = 12;
  localparam int IDLE_LIMIT = 20 * (CAP + 10);

  class kv_list_scoreboard;
    logic [KEY_W-1:0] keys[$];
    logic [VAL_W-1:0] values[$];
    okvl_out_t        pending_results[$];
    int capacity;
    int errors;
    int requests;
    int refused;
    int hits;

    function new(int cap);
      capacity = cap;
    endfunction

    function void note_request(okvl_in_t r);
      okvl_out_t e;
      int pos;
      e = '0;
      pos = -1;
      foreach (keys[i]) begin
        if (pos < 0 && keys[i] == r.key) pos = i;
      end
      case (okvl_action_t'(r.action))
        ACT_INSERT: begin
          if (keys.size() < capacity) begin
            keys.push_back(r.key);
            values.push_back(r.value);
            e.ok = 1'b1;
          end else begin
            refused++;
          end
        end
        ACT_DELETE: begin
          if (pos >= 0) begin
            keys.delete(pos);
            values.delete(pos);
            e.ok = 1'b1;
            hits++;
          end
        end
        ACT_SEARCH: begin
          if (pos >= 0) begin
            e.found_value = values[pos];
            e.ok = 1'b1;
            hits++;
          end
        end
        default: begin
          keys.delete();
          values.delete();
          e.ok = 1'b1;
        end
      endcase
      e.length    = LEN_W'(keys.size());
      e.empty_res = (keys.size() == 0);
      e.full_res  = (keys.size() == capacity);
      pending_results.push_back(e);
      requests++;
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(okvl_out_t got);
      okvl_out_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        return;
      end
      e = pending_results.pop_front();
      check_field("ok", 32'(e.ok), 32'(got.ok));
      check_field("found_value", e.found_value, got.found_value);
      check_field("length", 32'(e.length), 32'(got.length));
      check_field("empty_res", 32'(e.empty_res), 32'(got.empty_res));
      check_field("full_res", 32'(e.full_res), 32'(got.full_res));
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  okvl_in_t  in_req;
  logic      out_strobe;
  okvl_out_t out_res;

  kv_list_scoreboard sb;
  logic [KEY_W-1:0]  key_pool[POOL];
  int                idle_cycles;

  ordered_key_value_list #(.CAPACITY(CAP)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_res);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic okvl_in_t make_request(okvl_action_t act, logic [31:0] k,
                                            logic [31:0] v);
    okvl_in_t r;
    r.action = act;
    r.key    = k;
    r.value  = v;
    return r;
  endfunction

  // idle each cycle with probability pct
  function automatic int pick_gap(int pct);
    int gap;
    gap = 0;
    while (gap < 4 * CAP && $urandom_range(99) < pct) gap++;
    return gap;
  endfunction

  function automatic logic [31:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (sb.keys.size() > 0 && roll < 45) return sb.keys[$urandom_range(sb.keys.size() - 1)];
    if (roll < 80) return key_pool[$urandom_range(POOL - 1)];
    return $urandom;
  endfunction

  // mode 0 fills, mode 1 drains, mode 2 mixes every action
  function automatic okvl_in_t random_request(int mode);
    int roll;
    okvl_action_t act;
    roll = $urandom_range(99);
    case (mode)
      0: act = (roll < 85) ? ACT_INSERT : ACT_SEARCH;
      1: act = (roll < 70) ? ACT_DELETE : (roll < 90) ? ACT_SEARCH : ACT_INSERT;
      default: begin
        if (roll < 35) act = ACT_INSERT;
        else if (roll < 60) act = ACT_DELETE;
        else if (roll < 96) act = ACT_SEARCH;
        else act = ACT_CLEAR;
      end
    endcase
    return make_request(act, pick_key(), $urandom);
  endfunction

  task automatic send_request(okvl_in_t r, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int mode;
    int len;
    int pct;
    int phase;
    int prev_phase;
    okvl_in_t directed[$];

    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    idle_cycles = 0;
    sb          = new(CAP);
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_request(ACT_SEARCH, 32'h0000_0000, 32'h0));
    directed.push_back(make_request(ACT_DELETE, 32'h0000_0000, 32'h0));
    directed.push_back(make_request(ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(make_request(ACT_INSERT, 32'h8000_0000, 32'h0000_0000));
    directed.push_back(make_request(ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(make_request(ACT_INSERT, 32'h7FFF_FFFF, 32'h1234_5678));
    directed.push_back(make_request(ACT_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5));
    directed.push_back(make_request(ACT_INSERT, 32'h0000_0000, 32'h5A5A_5A5A));
    directed.push_back(make_request(ACT_SEARCH, 32'h7FFF_FFFF, 32'h0));
    directed.push_back(make_request(ACT_SEARCH, 32'h8000_0000, 32'h0));
    directed.push_back(make_request(ACT_SEARCH, 32'h0000_0001, 32'h0));
    directed.push_back(make_request(ACT_DELETE, 32'h7FFF_FFFF, 32'h0));
    directed.push_back(make_request(ACT_SEARCH, 32'h7FFF_FFFF, 32'h0));
    directed.push_back(make_request(ACT_DELETE, 32'h1234_5678, 32'h0));
    directed.push_back(make_request(ACT_DELETE, 32'h8000_0000, 32'h0));
    directed.push_back(make_request(ACT_DELETE, 32'h0000_0000, 32'h0));
    directed.push_back(make_request(ACT_SEARCH, 32'hFFFF_FFFF, 32'h0));
    directed.push_back(make_request(ACT_CLEAR,  32'h0000_0000, 32'h0));
    directed.push_back(make_request(ACT_SEARCH, 32'hFFFF_FFFF, 32'h0));
    foreach (directed[i]) send_request(directed[i], (i % 4 == 3) ? $urandom_range(1, CAP) : 0);
    drain_results();

    sent       = 0;
    prev_phase = 0;
    while (sent < N_RANDOM) begin
      mode = (sent == 0) ? 0 : $urandom_range(2);
      len  = (sent == 0) ? CAP + 8 : $urandom_range(8, 80);
      for (int j = 0; j < len && sent < N_RANDOM; j++) begin
        phase = (sent * 3) / N_RANDOM;
        if (phase != prev_phase) drain_results();
        prev_phase = phase;
        pct = (phase == 0) ? 33 : (phase == 1) ? 79 : 0;
        send_request(random_request(mode), pick_gap(pct));
        sent++;
      end
    end

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (CAP + 4) @(posedge clk);

    $display("Covered %0d requests: %0d inserts refused on a full list, %0d delete/search hits",
             sb.requests, sb.refused, sb.hits);
    $display("Idle mixes: sender 33%%, 79%%, then back-to-back; %0d mismatches", sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/okvl_pkg.sv
design/okvl_cell.sv
design/ordered_key_value_list.sv
dv/tb_ordered_key_value_list.sv
